### design/ple_pkg.sv
// Package of the positional list engine.
// Holds sizes, operation and status codes, the cell control struct and element helpers.
// No dependencies.
`default_nettype none
package ple_pkg;

    localparam int CAPACITY     = 128;
    localparam int ELEMENT_BITS = 32;

    // Width that holds a list length from zero up to CAPACITY.
    localparam int LEN_W  = $clog2(CAPACITY + 1);
    // Width used for position compares; it covers an 8-bit position and any length.
    localparam int CW     = (LEN_W > 9) ? LEN_W : 9;
    // The read path selects within groups of eight cells, then across groups.
    localparam int GRP    = 8;
    localparam int GRP_W  = 3;
    localparam int NGRP   = (CAPACITY + GRP - 1) / GRP;
    localparam int GH_W   = (NGRP > 1) ? $clog2(NGRP) : 1;

    typedef logic [ELEMENT_BITS-1:0] t_elem;
    typedef logic [CW-1:0]           t_pos;

    typedef enum logic [1:0] {
        FN_INSERT = 2'd0,
        FN_DELETE = 2'd1,
        FN_READ   = 2'd2,
        FN_NONE   = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_RSVD  = 2'd3
    } t_status;

    // Control broadcast to every cell of the chain.
    typedef struct packed {
        logic  ins;
        logic  del;
        t_pos  pos0;
        t_elem value;
    } t_cell_ctl;

    // Keep a 32-bit signed input in ELEMENT_BITS bits.
    function automatic t_elem to_elem(input logic [31:0] v);
        return t_elem'(signed'(v));
    endfunction

    // Sign-extend or truncate a stored element to the 32-bit result field.
    function automatic logic [31:0] widen_elem(input t_elem e);
        return 32'(signed'(e));
    endfunction

endpackage
`default_nettype wire

### design/ple_req_if.sv
// Request channel of the positional list engine: valid, ready and the request fields.
// Depends on ple_pkg.
`default_nettype none
interface ple_req_if;
    import ple_pkg::*;

    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [7:0]  position;
    logic [31:0] value;

    modport source (output valid, output func, output position, output value, input ready);
    modport sink   (input valid, input func, input position, input value, output ready);

endinterface
`default_nettype wire

### design/ple_rsp_if.sv
// Result channel of the positional list engine: valid, ready and the result fields.
// Depends on ple_pkg.
`default_nettype none
interface ple_rsp_if;
    import ple_pkg::*;

    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] data_out;
    logic [7:0]  count;

    modport source (output valid, output status, output data_out, output count, input ready);
    modport sink   (input valid, input status, input data_out, input count, output ready);

endinterface
`default_nettype wire

### design/ple_cell.sv
// One cell of the element chain: holds one list element and trades it with its neighbors.
// Depends on ple_pkg.
`default_nettype none
module ple_cell (
    input  wire logic               i_clk,
    input  wire ple_pkg::t_pos      i_index,
    input  wire ple_pkg::t_cell_ctl i_ctl,
    input  wire ple_pkg::t_elem     i_left,
    input  wire ple_pkg::t_elem     i_right,
    output ple_pkg::t_elem          o_data
);
    import ple_pkg::*;

    t_elem r_data;
    t_elem n_data;

    always_comb begin
        n_data = r_data;
        if (i_ctl.ins) begin
            if (i_index > i_ctl.pos0) begin
                n_data = i_left;
            end else if (i_index == i_ctl.pos0) begin
                n_data = i_ctl.value;
            end
        end else if (i_ctl.del && (i_index >= i_ctl.pos0)) begin
            n_data = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule
`default_nettype wire

### design/positional_list_engine.sv
// Top level of the positional list engine: request decode, the chain of element cells,
// the two-step read select and the result register.
// Depends on ple_pkg, ple_req_if, ple_rsp_if and ple_cell.
//
// Use: requests arrive on i_req (func, one-based position, value) and each gives exactly
// one result on o_rsp (status, data_out, count). A request is taken when valid and ready
// are both high at a rising edge of i_clk.
// Insert moves every element from the position onward one cell toward the end and stores
// the value; delete returns the element and moves the later ones one cell toward the
// front; read returns the element. All cells shift together at the edge that accepts the
// request, so the list update itself is done at that edge whatever the position.
// The element is picked within groups of eight cells while the request is presented and is
// latched at the accepting edge; the select step then picks across groups into the result
// register. i_req.ready is high only in the idle state, so a new request is taken only
// after the last one has left the select step.
// A result that the receiver has not taken waits in the output register while the next
// request is accepted; that request then waits in the select step until the output
// register frees up, so a stall on o_rsp never loses or repeats a result.
// Reset (i_rst_n low at a clock edge) empties the list and drops any pending result. The
// element cells are not cleared; only entries below the length are ever read.
`default_nettype none
module positional_list_engine (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    ple_req_if.sink    i_req,
    ple_rsp_if.source  o_rsp
);
    import ple_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SEL  = 2'b10
    } t_state;

    t_state           r_state;
    t_state           n_state;
    logic [LEN_W-1:0] r_len;
    logic [LEN_W-1:0] n_len;

    // Request decode.
    logic      accept;
    t_func     func;
    t_pos      pos_w;
    t_pos      len_w;
    t_pos      p0;
    t_status   n_status;
    logic      n_want;
    t_cell_ctl ctl;

    // Cell chain and read select.
    t_elem            cell_q   [CAPACITY];
    t_elem            cell_pad [NGRP*GRP];
    t_elem            grp_sel  [2**GH_W];
    t_elem            r_grp    [2**GH_W];
    logic [GH_W-1:0]  r_hi;
    logic             r_want;
    t_status          r_status;

    // Result register.
    logic        r_out_valid;
    logic [1:0]  r_out_status;
    logic [31:0] r_out_data;
    logic [7:0]  r_out_count;
    logic        out_free;

    assign accept   = i_req.valid && i_req.ready;
    assign func     = t_func'(i_req.func);
    assign out_free = !r_out_valid || o_rsp.ready;

    // Check the position against the current length and build the cell control.
    always_comb begin
        pos_w     = t_pos'(i_req.position);
        len_w     = t_pos'(r_len);
        p0        = pos_w - t_pos'(1);
        n_status  = ST_OK;
        n_want    = 1'b0;
        n_len     = r_len;
        ctl.ins   = 1'b0;
        ctl.del   = 1'b0;
        ctl.pos0  = p0;
        ctl.value = to_elem(i_req.value);
        case (func)
            FN_INSERT: begin
                if ((pos_w == '0) || (pos_w > (len_w + t_pos'(1)))) begin
                    n_status = ST_RANGE;
                end else if (len_w == t_pos'(CAPACITY)) begin
                    n_status = ST_FULL;
                end else begin
                    ctl.ins = accept;
                    n_len   = r_len + LEN_W'(1);
                end
            end
            FN_DELETE: begin
                if ((pos_w == '0) || (pos_w > len_w)) begin
                    n_status = ST_RANGE;
                end else begin
                    ctl.del = accept;
                    n_want  = 1'b1;
                    n_len   = r_len - LEN_W'(1);
                end
            end
            FN_READ: begin
                if ((pos_w == '0) || (pos_w > len_w)) begin
                    n_status = ST_RANGE;
                end else begin
                    n_want = 1'b1;
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    // The chain: each cell sees its left and right neighbor; the ends see zero.
    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        t_elem left_d;
        t_elem right_d;
        if (k == 0) begin : g_first
            assign left_d = '0;
        end else begin : g_mid_l
            assign left_d = cell_q[k-1];
        end
        if (k == CAPACITY - 1) begin : g_last
            assign right_d = '0;
        end else begin : g_mid_r
            assign right_d = cell_q[k+1];
        end
        ple_cell u_cell (
            .i_clk   (i_clk),
            .i_index (t_pos'(k)),
            .i_ctl   (ctl),
            .i_left  (left_d),
            .i_right (right_d),
            .o_data  (cell_q[k])
        );
    end

    // Pad the chain to whole groups so every group select has eight inputs.
    for (genvar k = 0; k < NGRP*GRP; k++) begin : g_pad
        if (k < CAPACITY) begin : g_real
            assign cell_pad[k] = cell_q[k];
        end else begin : g_zero
            assign cell_pad[k] = '0;
        end
    end

    // First select step: pick the element within each group by the low position bits.
    for (genvar g = 0; g < 2**GH_W; g++) begin : g_grp
        if (g < NGRP) begin : g_used
            assign grp_sel[g] = cell_pad[g*GRP + int'(p0[GRP_W-1:0])];
        end else begin : g_unused
            assign grp_sel[g] = '0;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_SEL;
                end
            end
            S_SEL: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_len <= n_len;
            end
            if ((r_state == S_SEL) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers: the group picks are taken from the cells before they shift.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_grp    <= grp_sel;
            r_hi     <= GH_W'(p0 >> GRP_W);
            r_want   <= n_want;
            r_status <= n_status;
        end
        if ((r_state == S_SEL) && out_free) begin
            r_out_status <= r_status;
            r_out_data   <= r_want ? widen_elem(r_grp[r_hi]) : 32'd0;
            r_out_count  <= 8'(r_len);
        end
    end

    assign i_req.ready    = (r_state == S_IDLE);
    assign o_rsp.valid    = r_out_valid;
    assign o_rsp.status   = r_out_status;
    assign o_rsp.data_out = r_out_data;
    assign o_rsp.count    = r_out_count;

endmodule
`default_nettype wire

### design/ple_checker.sv
// Checker for the positional list engine result channel, bound to the top level.
// Depends on ple_pkg and positional_list_engine.
`default_nettype none
module ple_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        i_ready,
    input wire logic [1:0]  i_status,
    input wire logic [31:0] i_data_out,
    input wire logic [7:0]  i_count
);
    import ple_pkg::*;

    // A result that is not taken stays, unchanged.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_ready) |=> (i_valid && $stable(i_status) && $stable(i_data_out)
                                   && $stable(i_count)))
        else $error("result changed while stalled");

    // The length never grows past the capacity.
    a_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (32'(i_count) <= (CAPACITY % 256) || CAPACITY >= 256))
        else $error("count beyond capacity");

    // A full report only comes with a full list.
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && (i_status == ST_FULL)) |-> (i_count == 8'(CAPACITY)))
        else $error("full status with list not full");

    // Any error gives zero data.
    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && (i_status != ST_OK)) |-> (i_data_out == 32'd0))
        else $error("nonzero data on error");

endmodule

bind positional_list_engine ple_checker u_ple_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (o_rsp.valid),
    .i_ready    (o_rsp.ready),
    .i_status   (o_rsp.status),
    .i_data_out (o_rsp.data_out),
    .i_count    (o_rsp.count)
);
`default_nettype wire
